FILE: sv/ppc_pkg.sv
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned ColorWidth   = 16;
  localparam int unsigned AddrWidth    = 5;
  localparam int unsigned DataWidth    = 32;

  localparam logic [7:0] LineWidthMax = 8'd160;

  localparam logic [2:0] RegRestoreBg   = 3'd0;
  localparam logic [2:0] RegTranspOn    = 3'd1;
  localparam logic [2:0] RegTranspIdx   = 3'd2;
  localparam logic [2:0] RegBgIdx       = 3'd3;
  localparam logic [2:0] RegTargetDisp  = 3'd4;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdPixel = 1'b1;

  typedef struct packed {
    logic       restore_background;
    logic       transparency_on;
    logic [7:0] transparent_index;
    logic [7:0] background_index;
    logic [2:0] target_display;
  } cfg_t;

  typedef struct packed {
    logic       draw;
    logic [7:0] rd_idx;
    logic [8:0] screen_x;
    logic       run_start;
  } scan_t;

endpackage

FILE: sv/ppc_ram.sv
`timescale 1ns / 1ps

module ppc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ppc_regs.sv
`timescale 1ns / 1ps

module ppc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppc_pkg::AddrWidth-1:0]  paddr,
  input  logic [ppc_pkg::DataWidth-1:0]  pwdata,
  output logic [ppc_pkg::DataWidth-1:0]  prdata,
  output ppc_pkg::cfg_t                  cfg_o
);

  ppc_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic [2:0]    reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        ppc_pkg::RegRestoreBg:  cfg_d.restore_background = pwdata[0];
        ppc_pkg::RegTranspOn:   cfg_d.transparency_on    = pwdata[0];
        ppc_pkg::RegTranspIdx:  cfg_d.transparent_index  = pwdata[7:0];
        ppc_pkg::RegBgIdx:      cfg_d.background_index   = pwdata[7:0];
        ppc_pkg::RegTargetDisp: cfg_d.target_display     = pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ppc_pkg::RegRestoreBg:  prdata = {31'd0, cfg_q.restore_background};
      ppc_pkg::RegTranspOn:   prdata = {31'd0, cfg_q.transparency_on};
      ppc_pkg::RegTranspIdx:  prdata = {24'd0, cfg_q.transparent_index};
      ppc_pkg::RegBgIdx:      prdata = {24'd0, cfg_q.background_index};
      ppc_pkg::RegTargetDisp: prdata = {29'd0, cfg_q.target_display};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/ppc_scan.sv
`timescale 1ns / 1ps

module ppc_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pix_acc_i,
  input  ppc_pkg::cfg_t cfg_i,
  input  logic [7:0]    pixel_index_i,
  input  logic [7:0]    line_x_i,
  input  logic          last_in_line_i,
  output ppc_pkg::scan_t scan_o
);

  logic [7:0] pos_q, pos_d;
  logic       prev_q, prev_d;
  logic       in_range;
  logic       is_transp;
  logic       skip;

  assign in_range  = pos_q < ppc_pkg::LineWidthMax;
  assign is_transp = pixel_index_i == cfg_i.transparent_index;
  assign skip      = !cfg_i.restore_background && cfg_i.transparency_on && is_transp;

  always_comb begin
    scan_o.draw      = in_range && !skip;
    scan_o.rd_idx    = (cfg_i.restore_background && is_transp) ? cfg_i.background_index
                                                                : pixel_index_i;
    scan_o.screen_x  = {1'b0, line_x_i} + {1'b0, pos_q};
    scan_o.run_start = !prev_q;
  end

  always_comb begin
    pos_d  = pos_q;
    prev_d = prev_q;
    if (pix_acc_i) begin
      if (last_in_line_i) begin
        pos_d  = '0;
        prev_d = 1'b0;
      end else if (in_range) begin
        pos_d  = pos_q + 8'd1;
        prev_d = !skip;
      end else begin
        pos_d  = ppc_pkg::LineWidthMax;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      prev_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      prev_q <= prev_d;
    end
  end

endmodule

FILE: sv/palette_pixel_compositor.sv
`timescale 1ns / 1ps

// Palette pixel compositor: palette index pixels in, RGB565 screen pixels out.
// Input channel (in_valid_i / in_stall_o) carries palette loads (cmd 0) and
// scanline pixels (cmd 1); output channel (out_valid_o / out_stall_i) carries
// one request per drawn pixel with display, screen x/y, color and run start.
// One input request is taken every cycle while the output is not blocked.
// A drawn pixel passes through the registered palette RAM read and then the
// output register before it shows on the output.
// Skipped, dropped and palette load requests give no output.
// A palette load is written at its accept edge, so a pixel in the very next
// cycle already sees the new entry.
// Reset clears the configuration registers, the line position and the
// previous-drawn flag; palette contents stay undefined until loaded.
// When the receiver stalls, the output holds; the pipeline stage behind it
// fills and then in_stall_o rises in the same cycle out_stall_i is seen.
// Configuration goes through the APB port, registers at byte offsets 4*i.
module palette_pixel_compositor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppc_pkg::AddrWidth-1:0] paddr,
  input  logic [ppc_pkg::DataWidth-1:0] pwdata,
  output logic [ppc_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [7:0]                    pixel_index_i,
  input  logic [15:0]                   palette_color_i,
  input  logic [7:0]                    line_x_i,
  input  logic [7:0]                    line_y_i,
  input  logic                          last_in_line_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    display_o,
  output logic [8:0]                    screen_x_o,
  output logic [7:0]                    screen_y_o,
  output logic [15:0]                   color_o,
  output logic                          run_start_o
);

  ppc_pkg::cfg_t  cfg;
  ppc_pkg::scan_t scan;

  logic        in_acc, pix_acc, load_acc;
  logic        s1_move, out_move;
  logic [15:0] ram_rdata;

  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  s1_disp_q;
  logic [8:0]  s1_x_q;
  logic [7:0]  s1_y_q;
  logic        s1_run_q;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_disp_q;
  logic [8:0]  out_x_q;
  logic [7:0]  out_y_q;
  logic [15:0] out_color_q;
  logic        out_run_q;

  assign pready = 1'b1;

  ppc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg_o  (cfg)
  );

  assign out_move   = !out_valid_q || !out_stall_i;
  assign s1_move    = !s1_valid_q || out_move;
  assign in_stall_o = !s1_move;
  assign in_acc     = in_valid_i && s1_move;
  assign pix_acc    = in_acc && (cmd_i == ppc_pkg::CmdPixel);
  assign load_acc   = in_acc && (cmd_i == ppc_pkg::CmdLoad);

  ppc_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_acc_i     (pix_acc),
    .cfg_i         (cfg),
    .pixel_index_i (pixel_index_i),
    .line_x_i      (line_x_i),
    .last_in_line_i(last_in_line_i),
    .scan_o        (scan)
  );

  ppc_ram #(
    .Width(ppc_pkg::ColorWidth),
    .Depth(ppc_pkg::PaletteDepth)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (load_acc),
    .waddr_i(pixel_index_i),
    .wdata_i(palette_color_i),
    .re_i   (pix_acc && scan.draw),
    .raddr_i(scan.rd_idx),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_move) begin
      s1_valid_d = pix_acc && scan.draw;
    end
    out_valid_d = out_valid_q;
    if (out_move) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc && scan.draw) begin
      s1_disp_q <= cfg.target_display;
      s1_x_q    <= scan.screen_x;
      s1_y_q    <= line_y_i;
      s1_run_q  <= scan.run_start;
    end
    if (out_move && s1_valid_q) begin
      out_disp_q  <= s1_disp_q;
      out_x_q     <= s1_x_q;
      out_y_q     <= s1_y_q;
      out_color_q <= ram_rdata;
      out_run_q   <= s1_run_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign display_o   = out_disp_q;
  assign screen_x_o  = out_x_q;
  assign screen_y_o  = out_y_q;
  assign color_o     = out_color_q;
  assign run_start_o = out_run_q;

endmodule

FILE: sv/ppc_checker.sv
`timescale 1ns / 1ps

module ppc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  display_o,
  input logic [8:0]  screen_x_o,
  input logic [7:0]  screen_y_o,
  input logic [15:0] color_o,
  input logic        run_start_o
);

  logic pix_acc;

  assign pix_acc = in_valid_i && !in_stall_o && (cmd_i == ppc_pkg::CmdPixel);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(screen_x_o)
      && $stable(color_o) && $stable(run_start_o) && $stable(display_o)
      && $stable(screen_y_o))
    else $error("stalled output request changed");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_stall_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i && out_valid_o)
    else $error("input stalled without output back-pressure");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !pix_acc && !$past(pix_acc) |=> !out_valid_o)
    else $error("output request without an accepted pixel");

endmodule

bind palette_pixel_compositor ppc_checker u_ppc_checker (.*);

FILE: tb/tb_palette_pixel_compositor.sv
`timescale 1ns / 1ps

module tb_palette_pixel_compositor;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseCount  = 6;
  localparam int unsigned PhaseItems  = 55;
  localparam int unsigned PlanRows    = 23;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  idx;
    logic [15:0] pcolor;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic        last;
  } req_t;

  typedef struct packed {
    logic [2:0]  disp;
    logic [8:0]  sx;
    logic [7:0]  sy;
    logic [15:0] color;
    logic        run_start;
  } pix_t;

  typedef struct packed {
    logic       is_reg;
    logic [2:0] reg_sel;
    logic [7:0] reg_val;
    req_t       req;
    logic       typed;
    logic       exp_has;
    pix_t       exp_pix;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ppc_pkg::AddrWidth-1:0] paddr = '0;
  logic [ppc_pkg::DataWidth-1:0] pwdata = '0;
  logic [ppc_pkg::DataWidth-1:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = ppc_pkg::CmdLoad;
  logic [7:0]  pixel_index_i = '0;
  logic [15:0] palette_color_i = '0;
  logic [7:0]  line_x_i = '0;
  logic [7:0]  line_y_i = '0;
  logic        last_in_line_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  display_o;
  logic [8:0]  screen_x_o;
  logic [7:0]  screen_y_o;
  logic [15:0] color_o;
  logic        run_start_o;

  logic [15:0]   palette [ppc_pkg::PaletteDepth];
  logic [7:0]    line_pos = '0;
  logic          prev_drawn = 1'b0;
  ppc_pkg::cfg_t cfg = '0;

  pix_t        screen_pixels_due [$];
  pix_t        want_pix;
  row_t        plan [PlanRows];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned tx_pct = 0;
  int unsigned rx_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;

  palette_pixel_compositor i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .pixel_index_i  (pixel_index_i),
    .palette_color_i(palette_color_i),
    .line_x_i       (line_x_i),
    .line_y_i       (line_y_i),
    .last_in_line_i (last_in_line_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .display_o      (display_o),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .color_o        (color_o),
    .run_start_o    (run_start_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic composite_pixel(input req_t r, output pix_t p);
    logic [7:0] idx;
    logic       skip;
    logic       drawn;
    idx = r.idx;
    skip = 1'b0;
    drawn = 1'b0;
    p = '0;
    if (r.cmd == ppc_pkg::CmdLoad) begin
      palette[r.idx] = r.pcolor;
      return 1'b0;
    end
    if (line_pos < ppc_pkg::LineWidthMax) begin
      if (cfg.restore_background) begin
        if (idx == cfg.transparent_index) idx = cfg.background_index;
      end else if (cfg.transparency_on && idx == cfg.transparent_index) begin
        skip = 1'b1;
      end
      if (skip) begin
        prev_drawn = 1'b0;
      end else begin
        p.disp = cfg.target_display;
        p.sx = {1'b0, r.lx} + {1'b0, line_pos};
        p.sy = r.ly;
        p.color = palette[idx];
        p.run_start = !prev_drawn;
        prev_drawn = 1'b1;
        drawn = 1'b1;
      end
      line_pos = line_pos + 8'd1;
    end
    if (r.last) begin
      line_pos = '0;
      prev_drawn = 1'b0;
    end
    return drawn;
  endfunction

  function automatic row_t cfg_row(input logic [2:0] sel, input logic [7:0] val);
    row_t w;
    w = '0;
    w.is_reg = 1'b1;
    w.reg_sel = sel;
    w.reg_val = val;
    return w;
  endfunction

  function automatic row_t load_row(input logic [7:0] idx, input logic [15:0] color,
                                    input logic [7:0] lx, input logic [7:0] ly,
                                    input logic last);
    row_t w;
    w = '0;
    w.req = '{ppc_pkg::CmdLoad, idx, color, lx, ly, last};
    w.typed = 1'b1;
    return w;
  endfunction

  function automatic row_t model_row(input logic [7:0] idx, input logic [7:0] lx,
                                     input logic [7:0] ly, input logic last);
    row_t w;
    w = '0;
    w.req = '{ppc_pkg::CmdPixel, idx, 16'h0000, lx, ly, last};
    return w;
  endfunction

  function automatic row_t skip_row(input logic [7:0] idx, input logic [7:0] lx,
                                    input logic [7:0] ly, input logic last);
    row_t w;
    w = model_row(idx, lx, ly, last);
    w.typed = 1'b1;
    return w;
  endfunction

  function automatic row_t drawn_row(input logic [7:0] idx, input logic [7:0] lx,
                                     input logic [7:0] ly, input logic last,
                                     input logic [2:0] disp, input logic [8:0] sx,
                                     input logic [7:0] sy, input logic [15:0] color,
                                     input logic rs);
    row_t w;
    w = skip_row(idx, lx, ly, last);
    w.exp_has = 1'b1;
    w.exp_pix = '{disp, sx, sy, color, rs};
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic drive_request(input req_t r, input logic typed, input logic typed_has,
                               input pix_t typed_pix);
    pix_t p;
    logic has;
    while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= r.cmd;
    pixel_index_i <= r.idx;
    palette_color_i <= r.pcolor;
    line_x_i <= r.lx;
    line_y_i <= r.ly;
    last_in_line_i <= r.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has = composite_pixel(r, p);
    if (typed) begin
      has = typed_has;
      p = typed_pix;
    end
    if (has) screen_pixels_due.push_back(p);
  endtask

  task automatic wait_screen_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (screen_pixels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] sel, input logic [7:0] val);
    wait_screen_drained();
    repeat (4) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      ppc_pkg::RegRestoreBg:  cfg.restore_background = val[0];
      ppc_pkg::RegTranspOn:   cfg.transparency_on = val[0];
      ppc_pkg::RegTranspIdx:  cfg.transparent_index = val;
      ppc_pkg::RegBgIdx:      cfg.background_index = val;
      ppc_pkg::RegTargetDisp: cfg.target_display = val[2:0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (screen_pixels_due.size() == 0) begin
        $display("%0t: pixel with none expected: display 0x%0h x 0x%0h y 0x%0h color 0x%0h",
                 $time, display_o, screen_x_o, screen_y_o, color_o);
        mismatches++;
      end else begin
        want_pix = screen_pixels_due.pop_front();
        check_field("display", 16'(want_pix.disp), 16'(display_o));
        check_field("screen_x", 16'(want_pix.sx), 16'(screen_x_o));
        check_field("screen_y", 16'(want_pix.sy), 16'(screen_y_o));
        check_field("color", want_pix.color, color_o);
        check_field("run_start", 16'(want_pix.run_start), 16'(run_start_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("tb_palette_pixel_compositor failed");
      $finish;
    end
  end

  initial begin
    req_t        r;
    int unsigned phase;
    int unsigned k;
    int unsigned left;
    int unsigned roll;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [7:0]  v_tidx;
    logic [7:0]  v_bidx;
    logic [2:0]  v_disp;
    logic        v_rb;
    logic        v_to;

    plan = '{
      load_row(8'h00, 16'h0000, 8'h00, 8'h00, 1'b0),
      load_row(8'hFF, 16'hFFFF, 8'h00, 8'h00, 1'b0),
      load_row(8'h5A, 16'hA5C3, 8'hFF, 8'hFF, 1'b1),
      drawn_row(8'h00, 8'h00, 8'h00, 1'b0, 3'd0, 9'd0, 8'd0, 16'h0000, 1'b1),
      drawn_row(8'hFF, 8'h00, 8'h00, 1'b0, 3'd0, 9'd1, 8'd0, 16'hFFFF, 1'b0),
      drawn_row(8'h5A, 8'h00, 8'h00, 1'b1, 3'd0, 9'd2, 8'd0, 16'hA5C3, 1'b0),
      drawn_row(8'hFF, 8'hFF, 8'hFF, 1'b0, 3'd0, 9'd255, 8'd255, 16'hFFFF, 1'b1),
      drawn_row(8'h00, 8'hFF, 8'hFF, 1'b1, 3'd0, 9'd256, 8'd255, 16'h0000, 1'b0),
      cfg_row(ppc_pkg::RegTranspOn, 8'd1),
      cfg_row(ppc_pkg::RegTranspIdx, 8'h5A),
      cfg_row(ppc_pkg::RegTargetDisp, 8'd7),
      skip_row(8'h5A, 8'h0A, 8'h03, 1'b0),
      drawn_row(8'h00, 8'h0A, 8'h03, 1'b0, 3'd7, 9'd11, 8'd3, 16'h0000, 1'b1),
      skip_row(8'h5A, 8'h0A, 8'h03, 1'b0),
      drawn_row(8'hFF, 8'h0A, 8'h03, 1'b1, 3'd7, 9'd13, 8'd3, 16'hFFFF, 1'b1),
      cfg_row(ppc_pkg::RegRestoreBg, 8'd1),
      cfg_row(ppc_pkg::RegBgIdx, 8'hFF),
      drawn_row(8'h5A, 8'h00, 8'h09, 1'b0, 3'd7, 9'd0, 8'd9, 16'hFFFF, 1'b1),
      model_row(8'h00, 8'h00, 8'h09, 1'b1),
      load_row(8'h5A, 16'h1234, 8'h80, 8'h7F, 1'b1),
      cfg_row(ppc_pkg::RegRestoreBg, 8'd0),
      cfg_row(ppc_pkg::RegTranspOn, 8'd0),
      model_row(8'h5A, 8'h00, 8'h00, 1'b1)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_register(plan[i].reg_sel, plan[i].reg_val);
      end else begin
        drive_request(plan[i].req, plan[i].typed, plan[i].exp_has, plan[i].exp_pix);
      end
    end

    left = 0;
    lx = '0;
    ly = '0;
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        1: begin
          v_rb = 1'b1; v_to = 1'b1; v_tidx = 8'hFF; v_bidx = 8'h00; v_disp = 3'd5;
        end
        2: begin
          v_rb = 1'b0; v_to = 1'b1; v_tidx = 8'h00; v_bidx = 8'hFF; v_disp = 3'd6;
        end
        default: begin
          v_rb = 1'($urandom_range(1));
          v_to = 1'($urandom_range(1));
          v_tidx = 8'($urandom);
          v_bidx = 8'($urandom);
          v_disp = 3'($urandom_range(7));
        end
      endcase
      write_register(ppc_pkg::RegRestoreBg, 8'(v_rb));
      write_register(ppc_pkg::RegTranspOn, 8'(v_to));
      write_register(ppc_pkg::RegTranspIdx, v_tidx);
      write_register(ppc_pkg::RegBgIdx, v_bidx);
      write_register(ppc_pkg::RegTargetDisp, 8'(v_disp));

      case (phase)
        1: begin tx_pct = 55; rx_pct = 0; end
        2: begin tx_pct = 0; rx_pct = 55; end
        3, 5: begin tx_pct = 33; rx_pct = 33; end
        default: begin tx_pct = 0; rx_pct = 0; end
      endcase

      if (phase == 0) begin
        for (k = 0; k < ppc_pkg::PaletteDepth; k++) begin
          r = '{ppc_pkg::CmdLoad, 8'(k), 16'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom_range(1))};
          drive_request(r, 1'b0, 1'b0, '0);
        end
        left = 170;
        lx = 8'($urandom);
        ly = 8'($urandom);
      end

      for (k = 0; k < PhaseItems; k++) begin
        if (phase == 4 && k == 10) hold_req = 1'b1;
        if (phase == 4 && k == 45) wait_screen_drained();
        if (left == 0) begin
          left = ($urandom_range(19) == 0) ? $urandom_range(200, 150) : $urandom_range(24, 1);
          lx = 8'($urandom);
          ly = 8'($urandom);
        end
        roll = $urandom_range(99);
        if (roll < 8) begin
          r = '{1'($urandom_range(1)), 8'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 1'($urandom_range(1))};
        end else if (roll < 14) begin
          r = '{ppc_pkg::CmdLoad, 8'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom), 1'($urandom_range(1))};
        end else begin
          left--;
          r.cmd = ppc_pkg::CmdPixel;
          r.idx = ($urandom_range(2) == 0) ? cfg.transparent_index : 8'($urandom);
          r.pcolor = 16'($urandom);
          r.lx = lx;
          r.ly = ly;
          r.last = (left == 0) && ($urandom_range(15) != 0);
        end
        drive_request(r, 1'b0, 1'b0, '0);
      end
    end

    wait_screen_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && screen_pixels_due.size() == 0) begin
      $display("tb_palette_pixel_compositor passed");
    end else begin
      $display("tb_palette_pixel_compositor failed");
    end
    $finish;
  end

endmodule
